// File: hdl/rtc_cal_pkg.sv
// types, constants and calendar helper functions shared by the calendar clock
package rtc_cal_pkg;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_SET_TIME = 2'd1,
        KIND_SET_DATE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_TIME = 2'd1,
        ST_BAD_DATE = 2'd2
    } status_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
    } rtc_time_t;

    localparam int InWidth  = 56;
    localparam int OutWidth = 48;

    localparam logic [13:0] YearMinSet = 14'd1800;
    localparam logic [13:0] YearMax    = 14'd9999;
    localparam logic [13:0] ResetYear  = 14'd1971;
    localparam logic [4:0]  HoursMax   = 5'd23;
    localparam logic [5:0]  MinSecMax  = 6'd59;
    localparam logic [3:0]  MonthMax   = 4'd12;
    localparam logic [3:0]  MonthFeb   = 4'd2;
    localparam logic [3:0]  MonthApr   = 4'd4;
    localparam logic [3:0]  MonthJun   = 4'd6;
    localparam logic [3:0]  MonthSep   = 4'd9;
    localparam logic [3:0]  MonthNov   = 4'd11;

    // inverse of 25 modulo 2^14, and the largest product that marks a multiple of 25
    localparam logic [13:0] Inv25      = 14'd7209;
    localparam logic [13:0] Mult25Max  = 14'd655;

    localparam rtc_time_t ResetTime = '{
        year:    ResetYear,
        month:   4'd1,
        day:     5'd1,
        seconds: 6'd0,
        minutes: 6'd0,
        hours:   5'd0
    };

    // 4/100/400 rule: a century is a multiple of 4 and of 25, and 400 is 16 times 25
    function automatic logic is_leap(input logic [13:0] year);
        logic [13:0] prod;
        logic        by25;
        prod = year * Inv25;
        by25 = (prod <= Mult25Max);
        return ((year[1:0] == 2'b00) && !by25) || ((year[3:0] == 4'b0000) && by25);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic [13:0] year);
        logic [4:0] len;
        unique case (month)
            MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
            MonthFeb: len = is_leap(year) ? 5'd29 : 5'd28;
            default:  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// File: hdl/calendar_clock_with_set_top.sv
// calendar clock top level: input register, calendar update, result register
// a word accepted into the input register raises m_tvalid once it moves on into the result register
// throughput: one word per cycle while m_tready stays high; a held result stalls s_tready
// the calendar update is one combinational pass between the input and result registers
// reset clears both valid flags and loads 00:00:00 on 1 January 1971
module calendar_clock_with_set_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // new_hours, new_minutes, new_seconds, new_day, new_month, new_year, zero fill
    input  logic [rtc_cal_pkg::InWidth-1:0] s_tdata,
    // kind
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hours_now, minutes_now, seconds_now, day_now, month_now, year_now, status, zero fill
    output logic [rtc_cal_pkg::OutWidth-1:0] m_tdata
);

    logic                   in_valid_reg;
    logic [1:0]             in_kind_reg;
    logic [48:0]            in_data_reg;
    logic                   out_valid_reg;
    rtc_cal_pkg::status_t   out_status_reg;
    rtc_cal_pkg::rtc_time_t state_reg;
    rtc_cal_pkg::rtc_time_t state_next;
    rtc_cal_pkg::status_t   status_next;
    logic                   advance;

    // the input stage moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser;
            in_data_reg <= s_tdata[48:0];
        end
    end

    rtc_cal_step u_step (
        .kind        (in_kind_reg),
        .new_hours   (in_data_reg[6:0]),
        .new_minutes (in_data_reg[13:7]),
        .new_seconds (in_data_reg[20:14]),
        .new_day     (in_data_reg[27:21]),
        .new_month   (in_data_reg[34:28]),
        .new_year    (in_data_reg[48:35]),
        .cur         (state_reg),
        .nxt         (state_next),
        .status      (status_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rtc_cal_pkg::ResetTime;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_status_reg <= status_next;
        end
    end

    // the result word shows the state register, which holds the time after the last word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_status_reg, state_reg.year, state_reg.month, state_reg.day,
                       state_reg.seconds, state_reg.minutes, state_reg.hours};

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.hours <= rtc_cal_pkg::HoursMax) && (state_reg.minutes <= rtc_cal_pkg::MinSecMax)
        && (state_reg.seconds <= rtc_cal_pkg::MinSecMax))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.month != 4'd0) && (state_reg.month <= rtc_cal_pkg::MonthMax)
        && (state_reg.year <= rtc_cal_pkg::YearMax) && (state_reg.day != 5'd0)
        && (state_reg.day <= rtc_cal_pkg::month_len(state_reg.month, state_reg.year)))
        else $error("calendar date out of range");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("calendar changed without a word moving on");

    a_bad_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (status_next != rtc_cal_pkg::ST_OK) |=> $stable(state_reg))
        else $error("rejected set command changed the calendar");

endmodule

// File: hdl/rtc_cal_step.sv
// next time and date and status for one word, from the current state
module rtc_cal_step (
    input  logic [1:0]             kind,
    input  logic [6:0]             new_hours,
    input  logic [6:0]             new_minutes,
    input  logic [6:0]             new_seconds,
    input  logic [6:0]             new_day,
    input  logic [6:0]             new_month,
    input  logic [13:0]            new_year,
    input  rtc_cal_pkg::rtc_time_t cur,
    output rtc_cal_pkg::rtc_time_t nxt,
    output rtc_cal_pkg::status_t   status
);

    logic       sec_wrap;
    logic       min_wrap;
    logic       hour_wrap;
    logic       day_wrap;
    logic       month_wrap;
    logic       time_ok;
    logic       date_ok;
    logic [4:0] set_len;

    assign sec_wrap   = (cur.seconds >= rtc_cal_pkg::MinSecMax);
    assign min_wrap   = (cur.minutes >= rtc_cal_pkg::MinSecMax);
    assign hour_wrap  = (cur.hours >= rtc_cal_pkg::HoursMax);
    assign day_wrap   = (cur.day >= rtc_cal_pkg::month_len(cur.month, cur.year));
    assign month_wrap = (cur.month >= rtc_cal_pkg::MonthMax);

    assign time_ok = (new_hours <= {2'b00, rtc_cal_pkg::HoursMax})
                  && (new_minutes <= {1'b0, rtc_cal_pkg::MinSecMax})
                  && (new_seconds <= {1'b0, rtc_cal_pkg::MinSecMax});

    assign set_len = rtc_cal_pkg::month_len(new_month[3:0], new_year);

    assign date_ok = (new_month != 7'd0)
                  && (new_month <= {3'b000, rtc_cal_pkg::MonthMax})
                  && (new_day != 7'd0)
                  && (new_day <= {2'b00, set_len})
                  && (new_year >= rtc_cal_pkg::YearMinSet)
                  && (new_year <= rtc_cal_pkg::YearMax);

    always_comb begin
        nxt    = cur;
        status = rtc_cal_pkg::ST_OK;
        unique case (kind)
            rtc_cal_pkg::KIND_TICK: begin
                // ripple the carry through each field only when all below wrap
                nxt.seconds = sec_wrap ? 6'd0 : cur.seconds + 6'd1;
                if (sec_wrap) begin
                    nxt.minutes = min_wrap ? 6'd0 : cur.minutes + 6'd1;
                end
                if (sec_wrap && min_wrap) begin
                    nxt.hours = hour_wrap ? 5'd0 : cur.hours + 5'd1;
                end
                if (sec_wrap && min_wrap && hour_wrap) begin
                    nxt.day = day_wrap ? 5'd1 : cur.day + 5'd1;
                    if (day_wrap) begin
                        nxt.month = month_wrap ? 4'd1 : cur.month + 4'd1;
                        if (month_wrap) begin
                            nxt.year = (cur.year >= rtc_cal_pkg::YearMax) ? 14'd0
                                     : cur.year + 14'd1;
                        end
                    end
                end
            end
            rtc_cal_pkg::KIND_SET_TIME: begin
                if (time_ok) begin
                    nxt.hours   = new_hours[4:0];
                    nxt.minutes = new_minutes[5:0];
                    nxt.seconds = new_seconds[5:0];
                end else begin
                    status = rtc_cal_pkg::ST_BAD_TIME;
                end
            end
            rtc_cal_pkg::KIND_SET_DATE: begin
                if (date_ok) begin
                    nxt.day   = new_day[4:0];
                    nxt.month = new_month[3:0];
                    nxt.year  = new_year;
                end else begin
                    status = rtc_cal_pkg::ST_BAD_DATE;
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

// File: tb/sv/calendar_checker.sv
// calendar clock checker: predicts the reading for each accepted word and compares results
module calendar_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [rtc_cal_pkg::InWidth-1:0]  s_tdata,
    input  logic [1:0]                       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [rtc_cal_pkg::OutWidth-1:0] m_tdata,
    output int                               fail_total,
    output int                               readings_left,
    output int                               readings_checked
);

    typedef struct packed {
        logic [1:0]             status;
        rtc_cal_pkg::rtc_time_t stamp;
    } reading_t;

    rtc_cal_pkg::rtc_time_t clock_now = rtc_cal_pkg::ResetTime;
    reading_t               readings_due[$];
    int                     mismatches = 0;
    int                     compared = 0;

    function automatic logic leap_year(input logic [13:0] y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic [13:0] y);
        case (m)
            rtc_cal_pkg::MonthApr, rtc_cal_pkg::MonthJun,
            rtc_cal_pkg::MonthSep, rtc_cal_pkg::MonthNov: return 5'd30;
            rtc_cal_pkg::MonthFeb: return leap_year(y) ? 5'd29 : 5'd28;
            default: return 5'd31;
        endcase
    endfunction

    function automatic rtc_cal_pkg::rtc_time_t one_second_later(
            input rtc_cal_pkg::rtc_time_t t);
        rtc_cal_pkg::rtc_time_t n;
        n = t;
        n.seconds = t.seconds + 6'd1;
        if (t.seconds == rtc_cal_pkg::MinSecMax) begin
            n.seconds = '0;
            n.minutes = t.minutes + 6'd1;
            if (t.minutes == rtc_cal_pkg::MinSecMax) begin
                n.minutes = '0;
                n.hours = t.hours + 5'd1;
                if (t.hours == rtc_cal_pkg::HoursMax) begin
                    n.hours = '0;
                    n.day = t.day + 5'd1;
                    if (t.day >= month_days(t.month, t.year)) begin
                        n.day = 5'd1;
                        n.month = t.month + 4'd1;
                        if (t.month >= rtc_cal_pkg::MonthMax) begin
                            n.month = 4'd1;
                            n.year = (t.year >= rtc_cal_pkg::YearMax) ? 14'd0
                                   : t.year + 14'd1;
                        end
                    end
                end
            end
        end
        return n;
    endfunction

    function automatic reading_t next_reading(input logic [1:0] kind,
                                              input logic [rtc_cal_pkg::InWidth-1:0] w);
        reading_t    r;
        logic [6:0]  h, mi, s, d, mo;
        logic [13:0] y;
        h  = w[6:0];
        mi = w[13:7];
        s  = w[20:14];
        d  = w[27:21];
        mo = w[34:28];
        y  = w[48:35];
        r.stamp  = clock_now;
        r.status = rtc_cal_pkg::ST_OK;
        case (kind)
            rtc_cal_pkg::KIND_TICK: r.stamp = one_second_later(clock_now);
            rtc_cal_pkg::KIND_SET_TIME: begin
                if (h > rtc_cal_pkg::HoursMax || mi > rtc_cal_pkg::MinSecMax
                        || s > rtc_cal_pkg::MinSecMax) begin
                    r.status = rtc_cal_pkg::ST_BAD_TIME;
                end else begin
                    r.stamp.hours   = h[4:0];
                    r.stamp.minutes = mi[5:0];
                    r.stamp.seconds = s[5:0];
                end
            end
            rtc_cal_pkg::KIND_SET_DATE: begin
                // month length only matters once the month itself is in range
                if (mo < 1 || mo > rtc_cal_pkg::MonthMax || d < 1
                        || y < rtc_cal_pkg::YearMinSet || y > rtc_cal_pkg::YearMax
                        || d > month_days(mo[3:0], y)) begin
                    r.status = rtc_cal_pkg::ST_BAD_DATE;
                end else begin
                    r.stamp.day   = d[4:0];
                    r.stamp.month = mo[3:0];
                    r.stamp.year  = y;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic string show(input reading_t r);
        return $sformatf("%02d:%02d:%02d %0d-%02d-%02d status %0d", r.stamp.hours,
                         r.stamp.minutes, r.stamp.seconds, r.stamp.year, r.stamp.month,
                         r.stamp.day, r.status);
    endfunction

    always @(posedge aclk) begin
        reading_t want, got;
        string    diff;
        if (!aresetn) begin
            clock_now = rtc_cal_pkg::ResetTime;
            readings_due.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                want = next_reading(s_tuser, s_tdata);
                clock_now = want.stamp;
                readings_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = reading_t'(m_tdata[41:0]);
                if (readings_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: %s", show(got));
                end else begin
                    want = readings_due.pop_front();
                    compared++;
                    diff = "";
                    if (got.stamp.hours !== want.stamp.hours) diff = {diff, " hours"};
                    if (got.stamp.minutes !== want.stamp.minutes) diff = {diff, " minutes"};
                    if (got.stamp.seconds !== want.stamp.seconds) diff = {diff, " seconds"};
                    if (got.stamp.day !== want.stamp.day) diff = {diff, " day"};
                    if (got.stamp.month !== want.stamp.month) diff = {diff, " month"};
                    if (got.stamp.year !== want.stamp.year) diff = {diff, " year"};
                    if (got.status !== want.status) diff = {diff, " status"};
                    if (m_tdata[rtc_cal_pkg::OutWidth-1:42] !== '0) diff = {diff, " fill"};
                    if (diff != "") begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d wrong in%s: expected %s, got %s", compared,
                                     diff, show(want), show(got));
                    end
                end
            end
        end
        fail_total       <= mismatches;
        readings_left    <= readings_due.size();
        readings_checked <= compared;
    end

endmodule

// File: tb/sv/testbench.sv
// testbench top for the calendar clock: stimulus, handshake jitter and verdict
module testbench;

    localparam int         CycleLimit = 100000;
    localparam logic [1:0] KindUnused = 2'd3;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [rtc_cal_pkg::InWidth-1:0]  s_tdata = '0;
    logic [1:0]                       s_tuser = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [rtc_cal_pkg::OutWidth-1:0] m_tdata;

    int fail_total, readings_left, readings_checked;
    int sent [4];
    int cycles = 0;
    bit jitter_on = 1'b1;

    calendar_clock_with_set_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    calendar_checker calendar_watch (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .fail_total       (fail_total),
        .readings_left    (readings_left),
        .readings_checked (readings_checked)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= !jitter_on || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // random bits in every field, fill kept at zero
    function automatic logic [rtc_cal_pkg::InWidth-1:0] noise_fields();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return {7'd0, r[48:0]};
    endfunction

    function automatic logic [13:0] pick_year();
        case ($urandom_range(0, 7))
            0: return 14'd1900;
            1: return 14'd2000;
            2: return 14'd2100;
            3: return 14'd9999;
            4: return 14'd1800;
            5: return 14'(4 * $urandom_range(450, 2499));
            default: return 14'($urandom_range(1800, 9999));
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic [1:0] kind,
                             input logic [rtc_cal_pkg::InWidth-1:0] w);
        while (jitter_on && $urandom_range(0, 99) < 11) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent[kind]++;
        @(negedge aclk);
    endtask

    task automatic tick();
        send_word(rtc_cal_pkg::KIND_TICK, noise_fields());
    endtask

    task automatic set_time(input logic [6:0] h, input logic [6:0] mi, input logic [6:0] s);
        logic [rtc_cal_pkg::InWidth-1:0] w;
        w = noise_fields();
        w[20:0] = {s, mi, h};
        send_word(rtc_cal_pkg::KIND_SET_TIME, w);
    endtask

    task automatic set_date(input logic [6:0] d, input logic [6:0] mo, input logic [13:0] y);
        logic [rtc_cal_pkg::InWidth-1:0] w;
        w = noise_fields();
        w[48:21] = {y, mo, d};
        send_word(rtc_cal_pkg::KIND_SET_DATE, w);
    endtask

    initial begin
        logic [3:0]  mo;
        logic [13:0] yr;
        logic [4:0]  last;
        logic [6:0]  dd;
        logic [1:0]  kind;
        int          n, pick, k;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // field extremes and every rejection path
        send_word(rtc_cal_pkg::KIND_TICK, '0);
        send_word(KindUnused, {7'd0, {49{1'b1}}});
        set_time(23, 59, 59);
        tick();
        set_time(24, 0, 0);
        set_time(0, 60, 0);
        set_time(0, 0, 60);
        set_time(127, 127, 127);
        set_time(0, 0, 0);
        set_date(31, 12, 9999);
        set_date(1, 1, 1800);
        set_date(1, 1, 1799);
        set_date(1, 1, 16383);
        set_date(1, 1, 10000);
        set_date(1, 0, 2000);
        set_date(1, 13, 2000);
        set_date(127, 127, 2000);
        set_date(0, 6, 2000);
        set_date(31, 4, 2001);
        set_date(29, 2, 1900);
        set_date(29, 2, 2023);
        set_date(29, 2, 2000);
        set_date(29, 2, 2024);
        set_date(28, 2, 2100);
        set_time(23, 59, 59);
        tick();

        // wrap into year 0 and walk day by day past its 29 February
        set_date(31, 12, 9999);
        set_time(23, 59, 59);
        tick();
        repeat (60) begin
            set_time(23, 59, 59);
            tick();
        end

        n = 0;
        while (n < 850) begin
            jitter_on = !(n >= 300 && n < 500);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // midnight rollover from a valid date, often the month's last day
                mo = ($urandom_range(0, 3) == 0) ? rtc_cal_pkg::MonthFeb
                                                 : 4'($urandom_range(1, 12));
                yr = pick_year();
                last = rtc_cal_pkg::month_len(mo, yr);
                dd = $urandom_range(0, 1) ? 7'(last) : 7'($urandom_range(1, last));
                set_date(dd, 7'(mo), yr);
                set_time($urandom_range(0, 3) ? 7'd23 : 7'($urandom_range(0, 23)),
                         $urandom_range(0, 3) ? 7'd59 : 7'($urandom_range(0, 59)),
                         7'($urandom_range(50, 59)));
                k = $urandom_range(1, 12);
                repeat (k) tick();
                n += 2 + k;
            end else if (pick < 72) begin
                k = $urandom_range(1, 6);
                repeat (k) tick();
                n += k;
            end else if (pick < 80) begin
                set_time(7'($urandom_range(0, 25)), 7'($urandom_range(0, 61)),
                         7'($urandom_range(0, 61)));
                n++;
            end else if (pick < 88) begin
                set_date(7'($urandom_range(0, 32)), 7'($urandom_range(0, 13)),
                         14'($urandom_range(1795, 10005)));
                n++;
            end else begin
                kind = 2'($urandom);
                send_word(kind, noise_fields());
                if (kind != KindUnused) n++;
            end
        end
        jitter_on = 1'b1;
        s_tvalid <= 1'b0;

        while (readings_left != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("sent %0d ticks, %0d set-time, %0d set-date and %0d unused-kind words",
                 sent[rtc_cal_pkg::KIND_TICK], sent[rtc_cal_pkg::KIND_SET_TIME],
                 sent[rtc_cal_pkg::KIND_SET_DATE], sent[KindUnused]);
        $display("%0d results checked over bad set values, leap and century februaries, %s",
                 readings_checked, "rollovers and year 0");
        if (fail_total == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
